### hw/rtl/stpf_pkg.sv
// Package: shared types and constants for the serial topic packet framer.
`default_nettype none

package stpf_pkg;

  localparam logic [7:0] SyncByte    = 8'hFF;
  localparam logic [7:0] VersionByte = 8'hFE;
  localparam logic [7:0] SumBase     = 8'hFF;

  localparam int unsigned IdxW = 4;

  // position of a result word within the words caused by one input word
  localparam logic [IdxW-1:0] IdxSync    = 4'd0;
  localparam logic [IdxW-1:0] IdxVersion = 4'd1;
  localparam logic [IdxW-1:0] IdxLenLo   = 4'd2;
  localparam logic [IdxW-1:0] IdxLenHi   = 4'd3;
  localparam logic [IdxW-1:0] IdxLenSum  = 4'd4;
  localparam logic [IdxW-1:0] IdxTopicLo = 4'd5;
  localparam logic [IdxW-1:0] IdxTopicHi = 4'd6;
  localparam logic [IdxW-1:0] IdxData    = 4'd7;
  localparam logic [IdxW-1:0] IdxCheck   = 4'd8;

  typedef struct packed {
    logic        err;
    logic        start;
    logic        closing;
    logic [15:0] len;
    logic [15:0] topic;
    logic [7:0]  data;
    logic [7:0]  chk;
  } job_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       packet_end;
    logic       error;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/stpf_if.sv
// Interfaces: input and output word channels of the packet framer.
`default_nettype none

interface stpf_in_if;
  logic        valid;
  logic        ready;
  logic        start_req;
  logic [15:0] topic;
  logic [15:0] payload_length;
  logic [7:0]  data_byte;

  modport source (output valid, start_req, topic, payload_length, data_byte, input ready);
  modport sink (input valid, start_req, topic, payload_length, data_byte, output ready);
endinterface

interface stpf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       packet_end;
  logic       error;

  modport source (output valid, out_byte, run_last, packet_end, error, input ready);
  modport sink (input valid, out_byte, run_last, packet_end, error, output ready);
endinterface

`default_nettype wire

### hw/rtl/stpf_emit.sv
// Emitter: job register and output register, one result word per cycle unless stalled.
`default_nettype none

module stpf_emit (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire stpf_pkg::job_t   job_i,
  output logic                  free_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output stpf_pkg::result_t     out_o
);
  import stpf_pkg::*;

  logic            job_valid_q;
  job_t            job_q;
  logic [IdxW-1:0] idx_q;
  logic            out_valid_q;
  result_t         out_q;

  logic            out_adv;
  logic            emit;
  logic            job_last;
  logic [7:0]      len_sum;
  result_t         res;

  assign out_adv  = !out_valid_q || out_ready_i;
  assign emit     = job_valid_q && out_adv;
  assign job_last = job_q.err || (idx_q == (job_q.closing ? IdxCheck : IdxData));
  assign free_o   = !job_valid_q || (emit && job_last);
  assign len_sum  = job_q.len[7:0] + job_q.len[15:8];

  always_comb begin
    res = '0;
    if (job_q.err) begin
      res.run_last = 1'b1;
      res.error    = 1'b1;
    end else begin
      unique case (idx_q)
        IdxSync:    res.out_byte = SyncByte;
        IdxVersion: res.out_byte = VersionByte;
        IdxLenLo:   res.out_byte = job_q.len[7:0];
        IdxLenHi:   res.out_byte = job_q.len[15:8];
        IdxLenSum:  res.out_byte = SumBase - len_sum;
        IdxTopicLo: res.out_byte = job_q.topic[7:0];
        IdxTopicHi: res.out_byte = job_q.topic[15:8];
        IdxData: begin
          res.out_byte = job_q.data;
          res.run_last = !job_q.closing;
        end
        IdxCheck: begin
          res.out_byte   = job_q.chk;
          res.run_last   = 1'b1;
          res.packet_end = 1'b1;
        end
        default: res = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      idx_q       <= IdxSync;
    end else if (load_i) begin
      job_valid_q <= 1'b1;
      idx_q       <= job_i.start ? IdxSync : IdxData;
    end else if (emit) begin
      if (job_last) begin
        job_valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      job_q <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

### hw/rtl/serial_topic_packet_framer_unit.sv
// Top level: serial topic packet framer with packet state and emitter.
// An accepted word is held in the job register; result words are registered.
// Throughput: one result word per cycle unless the output stalls; a start word
// yields 8 or 9 words, others 1 or 2, so one-word inputs are taken every cycle.
// The next input word is taken in the cycle its predecessor's last word moves out.
// Reset: asynchronous, active low; clears the packet state and empties the pipe.
`default_nettype none

module serial_topic_packet_framer_unit (
  input wire logic clk_i,
  input wire logic rst_ni,
  stpf_in_if.sink  in_i,
  stpf_out_if.source out_o
);
  import stpf_pkg::*;

  logic        open_q;
  logic [15:0] rem_q;
  logic [7:0]  sum_q;

  logic        free;
  logic        acc;
  logic [15:0] len_sat;
  logic [7:0]  base_sum;
  logic [15:0] base_rem;
  logic [7:0]  new_sum;
  logic [15:0] new_rem;
  logic        closing;
  logic        err;
  job_t        job_d;
  result_t     res;

  assign in_i.ready = free;
  assign acc        = in_i.valid && free;

  assign len_sat  = (in_i.payload_length == 16'd0) ? 16'd1 : in_i.payload_length;
  assign base_sum = in_i.start_req ? (in_i.topic[7:0] + in_i.topic[15:8]) : sum_q;
  assign base_rem = in_i.start_req ? len_sat : rem_q;
  assign new_sum  = base_sum + in_i.data_byte;
  assign new_rem  = base_rem - 16'd1;
  assign closing  = (new_rem == 16'd0);
  assign err      = !in_i.start_req && !open_q;

  always_comb begin
    job_d.err     = err;
    job_d.start   = in_i.start_req;
    job_d.closing = closing;
    job_d.len     = len_sat;
    job_d.topic   = in_i.topic;
    job_d.data    = in_i.data_byte;
    job_d.chk     = SumBase - new_sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      rem_q  <= 16'd0;
      sum_q  <= 8'd0;
    end else if (acc && !err) begin
      open_q <= !closing;
      rem_q  <= new_rem;
      sum_q  <= closing ? 8'd0 : new_sum;
    end
  end

  stpf_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (acc),
    .job_i       (job_d),
    .free_o      (free),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_o       (res)
  );

  assign out_o.out_byte   = res.out_byte;
  assign out_o.run_last   = res.run_last;
  assign out_o.packet_end = res.packet_end;
  assign out_o.error      = res.error;

endmodule

`default_nettype wire

### tb/sv/stpf_frame_checker.sv
// Checker: predicts the framed byte stream from accepted input words and compares results.
module stpf_frame_checker
  import stpf_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  stpf_in_if        in_i,
  stpf_out_if       out_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        words_in_o,
  output int        words_out_o,
  output int        packets_o,
  output int        strays_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic        pkt_open;
  logic [15:0] bytes_left;
  logic [7:0]  frame_sum;
  result_t     framed_q[$];

  function automatic result_t frame_byte(logic [7:0] b, logic last, logic pend, logic err);
    result_t r;
    r.out_byte   = b;
    r.run_last   = last;
    r.packet_end = pend;
    r.error      = err;
    return r;
  endfunction

  task automatic frame_word(input logic start, input logic [15:0] topic,
                            input logic [15:0] len, input logic [7:0] data);
    logic [15:0] n;
    logic [7:0]  len_sum;
    n = (len == 16'd0) ? 16'd1 : len;
    if (!start && !pkt_open) begin
      framed_q.push_back(frame_byte(8'h00, 1'b1, 1'b0, 1'b1));
      strays_o++;
    end else begin
      if (start) begin
        len_sum = n[7:0] + n[15:8];
        framed_q.push_back(frame_byte(SyncByte, 1'b0, 1'b0, 1'b0));
        framed_q.push_back(frame_byte(VersionByte, 1'b0, 1'b0, 1'b0));
        framed_q.push_back(frame_byte(n[7:0], 1'b0, 1'b0, 1'b0));
        framed_q.push_back(frame_byte(n[15:8], 1'b0, 1'b0, 1'b0));
        framed_q.push_back(frame_byte(SumBase - len_sum, 1'b0, 1'b0, 1'b0));
        framed_q.push_back(frame_byte(topic[7:0], 1'b0, 1'b0, 1'b0));
        framed_q.push_back(frame_byte(topic[15:8], 1'b0, 1'b0, 1'b0));
        pkt_open   = 1'b1;
        frame_sum  = topic[7:0] + topic[15:8];
        bytes_left = n;
        packets_o++;
      end
      frame_sum  = frame_sum + data;
      bytes_left = bytes_left - 16'd1;
      if (bytes_left == 16'd0) begin
        framed_q.push_back(frame_byte(data, 1'b0, 1'b0, 1'b0));
        framed_q.push_back(frame_byte(SumBase - frame_sum, 1'b1, 1'b1, 1'b0));
        pkt_open  = 1'b0;
        frame_sum = 8'h00;
      end else begin
        framed_q.push_back(frame_byte(data, 1'b1, 1'b0, 1'b0));
      end
    end
  endtask

  task automatic flag(input string what, input result_t want, input result_t got);
    fail_count_o++;
    if (fail_count_o <= 10) begin
      $display("%0t frame check: %s: expected byte %02h last %b end %b err %b",
               $realtime, what, want.out_byte, want.run_last, want.packet_end, want.error);
      $display("%0t frame check:   got byte %02h last %b end %b err %b",
               $realtime, got.out_byte, got.run_last, got.packet_end, got.error);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      pkt_open     = 1'b0;
      bytes_left   = 16'd0;
      frame_sum    = 8'h00;
      framed_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      words_in_o   = 0;
      words_out_o  = 0;
      packets_o    = 0;
      strays_o     = 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        words_out_o++;
        got = frame_byte(out_i.out_byte, out_i.run_last, out_i.packet_end, out_i.error);
        if (framed_q.size() == 0) begin
          flag("unexpected word", '0, got);
        end else begin
          want = framed_q.pop_front();
          if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
              got.packet_end !== want.packet_end || got.error !== want.error) begin
            flag("mismatch", want, got);
          end
        end
      end
      if (in_i.valid && in_i.ready) begin
        words_in_o++;
        frame_word(in_i.start_req, in_i.topic, in_i.payload_length, in_i.data_byte);
      end
      pending_o = framed_q.size();
    end
  end

endmodule

### tb/sv/serial_topic_packet_framer_unit_tb.sv
// Testbench top: clock, reset, packet stimulus and verdict for the packet framer.
module serial_topic_packet_framer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import stpf_pkg::*;

  localparam int TotalWords = 150;

  logic clk;
  logic rst_n;
  logic calm;
  int   sent;
  int   fail_count;
  int   pending;
  int   words_in;
  int   words_out;
  int   packets;
  int   strays;

  stpf_in_if  in_w ();
  stpf_out_if out_w ();

  serial_topic_packet_framer_unit dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_w),
    .out_o (out_w)
  );

  stpf_frame_checker frame_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_w),
    .out_i       (out_w),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .words_in_o  (words_in),
    .words_out_o (words_out),
    .packets_o   (packets),
    .strays_o    (strays)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("serial_topic_packet_framer_unit_tb: FAIL");
    $finish;
  end

  // receiver stalls
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_w.ready <= 1'b0;
    end else begin
      out_w.ready <= calm || ($urandom_range(99) >= 6);
    end
  end

  task automatic send_word(input logic start, input logic [15:0] topic,
                           input logic [15:0] len, input logic [7:0] data);
    if (!calm && $urandom_range(99) < 6) begin
      in_w.valid          <= 1'b0;
      in_w.start_req      <= 1'($urandom_range(1));
      in_w.topic          <= 16'($urandom);
      in_w.payload_length <= 16'($urandom);
      in_w.data_byte      <= 8'($urandom);
      @(posedge clk);
    end
    in_w.valid          <= 1'b1;
    in_w.start_req      <= start;
    in_w.topic          <= topic;
    in_w.payload_length <= len;
    in_w.data_byte      <= data;
    do @(posedge clk); while (!in_w.ready);
    sent++;
  endtask

  task automatic send_body(input int count);
    for (int i = 0; i < count; i++) begin
      send_word(1'b0, 16'($urandom), 16'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    int          pick;
    int          body;
    logic [15:0] len;
    sent                = 0;
    calm                = 1'b0;
    rst_n               <= 1'b0;
    in_w.valid          <= 1'b0;
    in_w.start_req      <= 1'b0;
    in_w.topic          <= 16'h0000;
    in_w.payload_length <= 16'h0000;
    in_w.data_byte      <= 8'h00;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // stray byte, zero length, single byte, extremes, abandoned packets
    send_word(1'b0, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_word(1'b1, 16'h0000, 16'h0000, 8'h00);
    send_word(1'b1, 16'hFFFF, 16'h0001, 8'hFF);
    send_word(1'b1, 16'h1234, 16'hFFFF, 8'hA5);
    send_word(1'b0, 16'h0000, 16'h0000, 8'h00);
    send_word(1'b0, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_word(1'b1, 16'h00FF, 16'h0003, 8'h01);
    send_word(1'b0, 16'h0000, 16'h0000, 8'h7F);
    send_word(1'b0, 16'h0000, 16'h0000, 8'h80);
    send_word(1'b1, 16'hFF00, 16'h0100, 8'h55);
    send_word(1'b1, 16'h8001, 16'h0002, 8'hAA);
    send_word(1'b0, 16'h0000, 16'h0000, 8'hFE);
    send_word(1'b0, 16'hAAAA, 16'h5555, 8'h80);
    send_word(1'b1, 16'hFFFF, 16'h00FF, 8'h00);
    send_word(1'b1, 16'h5A5A, 16'h0004, 8'hFF);
    send_body(3);

    while (sent < TotalWords) begin
      calm <= (sent >= 70 && sent < 115);
      pick = $urandom_range(99);
      if (pick < 10) begin
        send_body(1);
      end else begin
        if (pick < 16) begin
          len = 16'h0000;
        end else if (pick < 26) begin
          len = 16'($urandom_range(9, 65535));
        end else begin
          len = 16'($urandom_range(1, 8));
        end
        body = (len == 16'h0000) ? 0 : int'(len) - 1;
        if (body > 0 && $urandom_range(99) < 10) begin
          body = $urandom_range(0, body - 1);
        end
        if (body > 7) begin
          body = $urandom_range(0, 7);
        end
        send_word(1'b1, 16'($urandom), len, 8'($urandom));
        send_body(body);
      end
    end
    in_w.valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);

    $display("Run covered %0d input words (%0d packets opened, %0d stray bytes)",
             words_in, packets, strays);
    $display("and %0d framed output words with random gaps on both channels.", words_out);
    if (fail_count == 0 && pending == 0) begin
      $display("serial_topic_packet_framer_unit_tb: PASS");
    end else begin
      $display("serial_topic_packet_framer_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
